FILE: hw/rtl/mbrc_pkg.sv
// Shared types, codes and functions of the Modbus RTU response checker.
// No dependencies; every other file of the block imports this package.
package mbrc_pkg;

    localparam int TGT_W = 9;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [TGT_W-1:0] EXC_LEN = 9'd5;
    localparam logic [TGT_W-1:0] LEN_OFFSET = 9'd5;
    localparam logic [TGT_W-1:0] READ_REPLY_LEN = 9'd9;
    localparam logic [7:0] READ_BYTE_COUNT = 8'h04;
    localparam logic [7:0] STATUS_OVERRANGE = 8'h01;
    localparam logic [7:0] RANGE_MAX = 8'h02;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_TICK  = 2'd2
    } t_mode;

    localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [1:0] CFG_FUNC_CODE  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

    localparam logic [3:0] DIAG_OK        = 4'd0;
    localparam logic [3:0] DIAG_TIMEOUT   = 4'd1;
    localparam logic [3:0] DIAG_TOO_LARGE = 4'd2;
    localparam logic [3:0] DIAG_TOO_SHORT = 4'd3;
    localparam logic [3:0] DIAG_CRC       = 4'd4;
    localparam logic [3:0] DIAG_ADDRESS   = 4'd5;
    localparam logic [3:0] DIAG_EXCEPTION = 4'd6;
    localparam logic [3:0] DIAG_FORMAT    = 4'd7;
    localparam logic [3:0] DIAG_OVERRANGE = 4'd8;
    localparam logic [3:0] DIAG_STATUS    = 4'd9;
    localparam logic [3:0] DIAG_RANGE     = 4'd10;

    typedef struct packed {
        logic [7:0]  node_addr;
        logic [6:0]  function_code;
        logic [15:0] tick_limit;
    } t_cfg;

    typedef struct packed {
        logic [6:0][7:0]  head;
        logic [15:0]      rx_crc;
        logic [15:0]      calc_crc;
        logic [TGT_W-1:0] length;
    } t_frame_view;

    typedef struct packed {
        logic [3:0]       diagnostic;
        logic             measurement_valid;
        logic [7:0]       status_byte;
        logic [7:0]       range_code;
        logic [15:0]      meas_raw;
        logic [15:0]      rx_crc;
        logic [15:0]      calc_crc;
        logic [3:0]       frm_len;
        logic [7:0]       exc_code;
        logic [TGT_W-1:0] announced_length;
    } t_result;

    function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic t_result partial_result(input logic [3:0] diag, input logic [3:0] len,
                                               input logic have_count, input logic [7:0] b2);
        t_result r;
        r = '0;
        r.diagnostic = diag;
        r.frm_len = len;
        r.exc_code = have_count ? b2 : 8'h00;
        return r;
    endfunction

endpackage

FILE: hw/rtl/mbrc_parser.sv
// Checks a delimited frame: CRC, address, exception, format and measurement fields.
// Purely combinational; depends on mbrc_pkg.
module mbrc_parser #(
    parameter int FRAME_CAPACITY = 9
) (
    input  mbrc_pkg::t_frame_view i_view,
    input  mbrc_pkg::t_cfg        i_cfg,
    output mbrc_pkg::t_result     o_result
);
    import mbrc_pkg::*;

    localparam logic [TGT_W-1:0] CAP = TGT_W'(FRAME_CAPACITY);

    logic [7:0] b1_exc;

    assign b1_exc = {1'b1, i_cfg.function_code};

    always_comb begin
        o_result = '0;
        o_result.frm_len = i_view.length[3:0];
        o_result.exc_code = (i_view.length >= 9'd3) ? i_view.head[2] : 8'h00;
        if (i_view.length < EXC_LEN || i_view.length > CAP) begin
            o_result.diagnostic = DIAG_TOO_SHORT;
        end else begin
            o_result.rx_crc = i_view.rx_crc;
            o_result.calc_crc = i_view.calc_crc;
            priority if (i_view.rx_crc != i_view.calc_crc) begin
                o_result.diagnostic = DIAG_CRC;
            end else if (i_view.head[0] != i_cfg.node_addr) begin
                o_result.diagnostic = DIAG_ADDRESS;
            end else if (i_view.head[1] == b1_exc) begin
                o_result.diagnostic = DIAG_EXCEPTION;
            end else if (i_view.length != READ_REPLY_LEN
                         || i_view.head[1] != {1'b0, i_cfg.function_code}
                         || i_view.head[2] != READ_BYTE_COUNT) begin
                o_result.diagnostic = DIAG_FORMAT;
            end else begin
                o_result.status_byte = i_view.head[3];
                o_result.range_code = i_view.head[4];
                o_result.meas_raw = {i_view.head[5], i_view.head[6]};
                priority if (i_view.head[3] == STATUS_OVERRANGE) begin
                    o_result.diagnostic = DIAG_OVERRANGE;
                end else if (i_view.head[3] != 8'h00) begin
                    o_result.diagnostic = DIAG_STATUS;
                end else if (i_view.head[4] > RANGE_MAX) begin
                    o_result.diagnostic = DIAG_RANGE;
                end else begin
                    o_result.diagnostic = DIAG_OK;
                end
                o_result.measurement_valid = (o_result.diagnostic == DIAG_OK);
            end
        end
    end

endmodule

FILE: hw/rtl/mbrc_frame_tracker.sv
// Reception state of one reply: byte count, length, running CRC, ticks and stored header bytes.
// Depends on mbrc_pkg and instantiates mbrc_parser.
module mbrc_frame_tracker #(
    parameter int FRAME_CAPACITY = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_data_byte,
    input  mbrc_pkg::t_cfg    i_cfg,
    output logic              o_res_valid,
    output mbrc_pkg::t_result o_result
);
    import mbrc_pkg::*;

    localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(FRAME_CAPACITY);
    localparam logic [TGT_W-1:0] CAP_TGT = TGT_W'(FRAME_CAPACITY);

    logic [CNT_W-1:0] r_count, n_count;
    logic [TGT_W-1:0] r_target, n_target;
    logic [15:0]      r_crc0, n_crc0;
    logic [15:0]      r_crc1, n_crc1;
    logic [15:0]      r_elapsed, n_elapsed;
    logic             r_awaiting, n_awaiting;
    logic [6:0][7:0]  r_head, n_head;
    logic [7:0]       r_last, n_last;

    logic [CNT_W-1:0] count_inc;
    logic [TGT_W-1:0] count_inc_w;
    logic [15:0]      limit;
    logic [TGT_W-1:0] byte_target;
    t_frame_view      view;
    t_result          parsed;

    assign count_inc = r_count + 1'b1;
    assign count_inc_w = TGT_W'(count_inc);
    assign limit = (i_cfg.tick_limit == 16'h0000) ? 16'h0001 : i_cfg.tick_limit;

    always_comb begin
        for (int i = 0; i < 7; i++) begin
            n_head[i] = (r_count == CNT_W'(i)) ? i_data_byte : r_head[i];
        end
    end

    always_comb begin
        if (count_inc_w >= 9'd2 && n_head[1][7]) begin
            byte_target = EXC_LEN;
        end else if (count_inc_w >= 9'd3) begin
            byte_target = TGT_W'(n_head[2]) + LEN_OFFSET;
        end else begin
            byte_target = r_target;
        end
    end

    assign view.head = n_head;
    assign view.rx_crc = {i_data_byte, r_last};
    assign view.calc_crc = r_crc1;
    assign view.length = byte_target;

    mbrc_parser #(
        .FRAME_CAPACITY(FRAME_CAPACITY)
    ) u_parser (
        .i_view  (view),
        .i_cfg   (i_cfg),
        .o_result(parsed)
    );

    always_comb begin
        n_count = r_count;
        n_target = r_target;
        n_crc0 = r_crc0;
        n_crc1 = r_crc1;
        n_elapsed = r_elapsed;
        n_awaiting = r_awaiting;
        n_last = r_last;
        o_res_valid = 1'b0;
        o_result = '0;
        if (i_step) begin
            unique case (i_mode)
                MODE_START: begin
                    n_count = '0;
                    n_target = '0;
                    n_crc0 = CRC_INIT;
                    n_crc1 = CRC_INIT;
                    n_elapsed = '0;
                    n_awaiting = 1'b1;
                end
                MODE_TICK: begin
                    if (r_awaiting) begin
                        n_elapsed = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
                        if (n_elapsed >= limit) begin
                            o_res_valid = 1'b1;
                            o_result = partial_result(DIAG_TIMEOUT, r_count[3:0],
                                                      TGT_W'(r_count) >= 9'd3, r_head[2]);
                            n_awaiting = 1'b0;
                        end
                    end
                end
                MODE_BYTE: begin
                    if (r_awaiting) begin
                        if (r_count >= CAP_CNT) begin
                            o_res_valid = 1'b1;
                            o_result = partial_result(DIAG_TIMEOUT, r_count[3:0],
                                                      TGT_W'(r_count) >= 9'd3, r_head[2]);
                            n_awaiting = 1'b0;
                        end else begin
                            n_count = count_inc;
                            n_crc1 = r_crc0;
                            n_crc0 = crc_step(r_crc0, i_data_byte);
                            n_last = i_data_byte;
                            n_target = byte_target;
                            priority if (byte_target > CAP_TGT) begin
                                o_res_valid = 1'b1;
                                o_result = partial_result(DIAG_TOO_LARGE, count_inc[3:0],
                                                          1'b1, n_head[2]);
                                o_result.announced_length = byte_target;
                                n_awaiting = 1'b0;
                            end else if (byte_target != '0 && count_inc_w >= byte_target) begin
                                o_res_valid = 1'b1;
                                o_result = parsed;
                                n_awaiting = 1'b0;
                            end else if (count_inc >= CAP_CNT) begin
                                o_res_valid = 1'b1;
                                o_result = partial_result(DIAG_TIMEOUT, count_inc[3:0],
                                                          count_inc_w >= 9'd3, n_head[2]);
                                n_awaiting = 1'b0;
                            end else begin
                                n_awaiting = r_awaiting;
                            end
                        end
                    end
                end
                default: begin
                    n_awaiting = r_awaiting;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_target <= '0;
            r_crc0 <= CRC_INIT;
            r_crc1 <= CRC_INIT;
            r_elapsed <= '0;
            r_awaiting <= 1'b0;
        end else begin
            r_count <= n_count;
            r_target <= n_target;
            r_crc0 <= n_crc0;
            r_crc1 <= n_crc1;
            r_elapsed <= n_elapsed;
            r_awaiting <= n_awaiting;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_mode == MODE_BYTE && r_awaiting && r_count < CAP_CNT) begin
            r_head <= n_head;
        end
        r_last <= n_last;
    end

endmodule

FILE: hw/rtl/modbus_rtu_response_checker.sv
// Top level of the Modbus RTU read-reply checker: input register, configuration
// registers and result register around the frame tracker. Depends on mbrc_pkg.
//
// Usage: the input channel (i_valid, o_stall, i_mode, i_data_byte) carries one request
// per received event: a start command, a received byte or a timer tick. The output
// channel (o_valid, i_stall and the result fields) carries one result per completed,
// failed or timed-out reply. Configuration is written through i_cfg_we, i_cfg_index
// and i_cfg_data while the block is idle; indexes beyond the register list are ignored.
// An accepted request is held in the input register until it advances; its result, if
// any, is then registered in the result register that drives o_valid. One request is
// taken every cycle while the output is not stalled; the whole byte step, including the
// sixteen-bit CRC update and the frame checks, is combinational logic between registers.
// When the receiver stalls, the pending result holds and the input register fills;
// o_stall then rises until the result is taken.
// Reset clears the handshake, returns the registers to their defaults and leaves the
// block idle, so bytes and ticks are ignored until a start command arrives.
module modbus_rtu_response_checker #(
    parameter int FRAME_CAPACITY = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_diagnostic,
    output logic        o_measurement_valid,
    output logic [7:0]  o_status_byte,
    output logic [7:0]  o_range_code,
    output logic [15:0] o_meas_raw,
    output logic [15:0] o_rx_crc,
    output logic [15:0] o_calc_crc,
    output logic [3:0]  o_frm_len,
    output logic [7:0]  o_exc_code,
    output logic [8:0]  o_announced_length
);
    import mbrc_pkg::*;

    logic       r_in_valid;
    logic [1:0] r_in_mode;
    logic [7:0] r_in_byte;
    t_cfg       r_cfg;
    logic       r_out_valid;
    t_result    r_out;

    logic       advance;
    logic       accept_in;
    logic       res_valid;
    t_result    res;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign accept_in = i_valid && !o_stall;

    mbrc_frame_tracker #(
        .FRAME_CAPACITY(FRAME_CAPACITY)
    ) u_tracker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_mode     (r_in_mode),
        .i_data_byte(r_in_byte),
        .i_cfg      (r_cfg),
        .o_res_valid(res_valid),
        .o_result   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg.node_addr <= 8'd1;
            r_cfg.function_code <= 7'd3;
            r_cfg.tick_limit <= 16'd100;
        end else begin
            if (accept_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= res_valid;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SLAVE_ADDR: r_cfg.node_addr <= i_cfg_data[7:0];
                    CFG_FUNC_CODE:  r_cfg.function_code <= i_cfg_data[6:0];
                    CFG_TIMEOUT:    r_cfg.tick_limit <= i_cfg_data;
                    default:        r_cfg <= r_cfg;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_mode <= i_mode;
            r_in_byte <= i_data_byte;
        end
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_diagnostic = r_out.diagnostic;
    assign o_measurement_valid = r_out.measurement_valid;
    assign o_status_byte = r_out.status_byte;
    assign o_range_code = r_out.range_code;
    assign o_meas_raw = r_out.meas_raw;
    assign o_rx_crc = r_out.rx_crc;
    assign o_calc_crc = r_out.calc_crc;
    assign o_frm_len = r_out.frm_len;
    assign o_exc_code = r_out.exc_code;
    assign o_announced_length = r_out.announced_length;

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for modbus_rtu_response_checker: random and directed reply frames,
// a clocked driver and monitor on the request and verdict channels, and a bit-exact
// predictor of the frame checks. Depends on mbrc_pkg and the checker RTL.
`timescale 1ns / 100ps

module tb_top;
    import mbrc_pkg::*;

    localparam int FRAME_CAPACITY = 9;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 150;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] mode;
        logic [7:0] data;
    } t_uart_item;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_mode = MODE_START;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_SLAVE_ADDR;
    logic [15:0] i_cfg_data = 16'h0000;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [3:0]  o_diagnostic;
    logic        o_measurement_valid;
    logic [7:0]  o_status_byte;
    logic [7:0]  o_range_code;
    logic [15:0] o_meas_raw;
    logic [15:0] o_rx_crc;
    logic [15:0] o_calc_crc;
    logic [3:0]  o_frm_len;
    logic [7:0]  o_exc_code;
    logic [8:0]  o_announced_length;

    t_uart_item  uart_events[$];
    t_result     expected_verdicts[$];
    t_uart_item  next_item;
    int unsigned events_queued = 0;
    int unsigned idle_pct = 35;
    int unsigned mismatches = 0;
    int unsigned verdicts_seen = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned quiet_cycles = 0;

    logic [7:0]  exp_addr = 8'd1;
    logic [6:0]  exp_func = 7'd3;
    logic [15:0] exp_timeout = 16'd100;

    logic [7:0]  frm_bytes [FRAME_CAPACITY];
    int unsigned frm_count = 0;
    int unsigned frm_target = 0;
    logic [15:0] crc_hist [3] = '{CRC_INIT, CRC_INIT, CRC_INIT};
    logic [15:0] tick_count = 16'd0;
    bit          armed = 1'b0;

    modbus_rtu_response_checker #(
        .FRAME_CAPACITY(FRAME_CAPACITY)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_mode(i_mode),
        .i_data_byte(i_data_byte),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_diagnostic(o_diagnostic),
        .o_measurement_valid(o_measurement_valid),
        .o_status_byte(o_status_byte),
        .o_range_code(o_range_code),
        .o_meas_raw(o_meas_raw),
        .o_rx_crc(o_rx_crc),
        .o_calc_crc(o_calc_crc),
        .o_frm_len(o_frm_len),
        .o_exc_code(o_exc_code),
        .o_announced_length(o_announced_length)
    );

    function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic t_result partial_verdict(input logic [3:0] diag);
        t_result r;
        r = '0;
        r.diagnostic = diag;
        r.frm_len = 4'(frm_count);
        if (frm_count >= 3) r.exc_code = frm_bytes[2];
        return r;
    endfunction

    function automatic t_result judge_frame(input int unsigned n);
        t_result r;
        logic [15:0] got_crc;
        r = '0;
        r.frm_len = 4'(n);
        r.exc_code = frm_bytes[2];
        if (n < EXC_LEN || n > FRAME_CAPACITY) begin
            r.diagnostic = DIAG_TOO_SHORT;
            return r;
        end
        got_crc = {frm_bytes[n-1], frm_bytes[n-2]};
        r.rx_crc = got_crc;
        r.calc_crc = crc_hist[2];
        if (got_crc != crc_hist[2]) begin
            r.diagnostic = DIAG_CRC;
        end else if (frm_bytes[0] != exp_addr) begin
            r.diagnostic = DIAG_ADDRESS;
        end else if (frm_bytes[1] == {1'b1, exp_func}) begin
            r.diagnostic = DIAG_EXCEPTION;
        end else if (n != READ_REPLY_LEN || frm_bytes[1] != {1'b0, exp_func}
                     || frm_bytes[2] != READ_BYTE_COUNT) begin
            r.diagnostic = DIAG_FORMAT;
        end else begin
            r.status_byte = frm_bytes[3];
            r.range_code = frm_bytes[4];
            r.meas_raw = {frm_bytes[5], frm_bytes[6]};
            if (frm_bytes[3] == STATUS_OVERRANGE) begin
                r.diagnostic = DIAG_OVERRANGE;
            end else if (frm_bytes[3] != 8'h00) begin
                r.diagnostic = DIAG_STATUS;
            end else if (frm_bytes[4] > RANGE_MAX) begin
                r.diagnostic = DIAG_RANGE;
            end else begin
                r.diagnostic = DIAG_OK;
                r.measurement_valid = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic predict_reply_check(input logic [1:0] mode, input logic [7:0] b);
        t_result     r;
        logic [15:0] lim;
        bit          done;
        r = '0;
        done = 1'b0;
        if (mode == MODE_START) begin
            frm_count = 0;
            frm_target = 0;
            crc_hist = '{CRC_INIT, CRC_INIT, CRC_INIT};
            tick_count = 16'd0;
            armed = 1'b1;
        end else if (armed && mode == MODE_TICK) begin
            lim = (exp_timeout == 16'd0) ? 16'd1 : exp_timeout;
            if (tick_count != 16'hFFFF) tick_count++;
            if (tick_count >= lim) begin
                r = partial_verdict(DIAG_TIMEOUT);
                done = 1'b1;
            end
        end else if (armed && mode == MODE_BYTE) begin
            if (frm_count >= FRAME_CAPACITY) begin
                r = partial_verdict(DIAG_TIMEOUT);
                done = 1'b1;
            end else begin
                frm_bytes[frm_count] = b;
                crc_hist[2] = crc_hist[1];
                crc_hist[1] = crc_hist[0];
                crc_hist[0] = crc16_byte(crc_hist[0], b);
                frm_count++;
                if (frm_count >= 2 && frm_bytes[1][7]) begin
                    frm_target = EXC_LEN;
                end else if (frm_count >= 3) begin
                    frm_target = int'(frm_bytes[2]) + int'(LEN_OFFSET);
                    if (frm_target > FRAME_CAPACITY) begin
                        r = partial_verdict(DIAG_TOO_LARGE);
                        r.announced_length = 9'(frm_target);
                        done = 1'b1;
                    end
                end
                if (!done && frm_target != 0 && frm_count >= frm_target) begin
                    r = judge_frame(frm_target);
                    done = 1'b1;
                end else if (!done && frm_count >= FRAME_CAPACITY) begin
                    r = partial_verdict(DIAG_TIMEOUT);
                    done = 1'b1;
                end
            end
        end
        if (done) begin
            armed = 1'b0;
            expected_verdicts.push_back(r);
        end
    endtask

    task automatic push_event(input logic [1:0] mode, input logic [7:0] data);
        t_uart_item it;
        it.mode = mode;
        it.data = data;
        uart_events.push_back(it);
        events_queued++;
    endtask

    task automatic append_crc(ref logic [7:0] frm[$]);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frm[i]) c = crc16_byte(c, frm[i]);
        frm.push_back(c[7:0]);
        frm.push_back(c[15:8]);
    endtask

    task automatic push_frame(input logic [7:0] frm[$]);
        foreach (frm[i]) begin
            if ($urandom_range(99) < 3) push_event(MODE_TICK, 8'($urandom_range(255)));
            push_event(MODE_BYTE, frm[i]);
        end
    endtask

    task automatic build_read_reply(ref logic [7:0] frm[$], input logic [7:0] addr);
        int unsigned roll;
        frm = {addr, {1'b0, exp_func}, READ_BYTE_COUNT};
        roll = $urandom_range(99);
        frm.push_back(roll < 70 ? 8'h00 : roll < 80 ? STATUS_OVERRANGE : 8'($urandom_range(255)));
        frm.push_back($urandom_range(99) < 75 ? 8'($urandom_range(2)) : 8'($urandom_range(255)));
        frm.push_back(8'($urandom_range(255)));
        frm.push_back(8'($urandom_range(255)));
    endtask

    task automatic queue_random_replies(input int unsigned budget);
        logic [7:0]  frm[$];
        int unsigned first;
        int unsigned pick;
        int unsigned k;
        int unsigned n_ticks;
        first = events_queued;
        while (events_queued - first < budget) begin
            pick = $urandom_range(99);
            if (pick < 7) begin
                repeat ($urandom_range(1, 6))
                    push_event(2'($urandom_range(3)), 8'($urandom_range(255)));
                continue;
            end
            push_event(MODE_START, 8'($urandom_range(255)));
            frm.delete();
            if (pick < 47 || pick >= 83) begin
                build_read_reply(frm, exp_addr);
            end else if (pick < 59) begin
                frm = {exp_addr, $urandom_range(3) == 0 ? {1'b1, 7'($urandom_range(127))}
                                                       : {1'b1, exp_func},
                       8'($urandom_range(255))};
            end else if (pick < 67) begin
                build_read_reply(frm, exp_addr ^ 8'($urandom_range(1, 255)));
            end else if (pick < 75) begin
                if ($urandom_range(1) == 0) begin
                    k = $urandom_range(3);
                    frm = {exp_addr, {1'b0, exp_func}, 8'(k)};
                    repeat (k) frm.push_back(8'($urandom_range(255)));
                end else begin
                    build_read_reply(frm, exp_addr);
                    frm[1] = {1'b0, exp_func ^ 7'($urandom_range(1, 127))};
                end
            end else begin
                frm = {exp_addr, {1'b0, exp_func}, 8'($urandom_range(5, 255))};
                repeat ($urandom_range(0, 4)) frm.push_back(8'($urandom_range(255)));
                push_frame(frm);
                continue;
            end
            append_crc(frm);
            if (pick >= 83 && pick < 92) begin
                k = $urandom_range(frm.size() - 1);
                frm[k] = frm[k] ^ (8'h01 << $urandom_range(7));
            end else if (pick >= 92) begin
                k = $urandom_range(frm.size() - 1);
                while (frm.size() > k) void'(frm.pop_back());
            end
            push_frame(frm);
            if (pick >= 92) begin
                n_ticks = (exp_timeout == 16'd0) ? 1 : (exp_timeout > 120) ? 120 : exp_timeout;
                repeat (n_ticks) push_event(MODE_TICK, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic queue_directed();
        logic [7:0] frm[$];
        push_event(MODE_BYTE, 8'hFF);
        push_event(MODE_TICK, 8'h00);
        push_event(MODE_UNUSED, 8'hA5);
        push_event(MODE_START, 8'h00);
        push_event(MODE_UNUSED, 8'h5A);
        push_event(MODE_START, 8'hFF);
        frm = {8'h01, 8'h03, READ_BYTE_COUNT, 8'h00, 8'h00, 8'hFF, 8'hFF};
        append_crc(frm);
        push_frame(frm);
        push_event(MODE_START, 8'h00);
        frm = {8'h01, 8'h83, 8'h02};
        append_crc(frm);
        push_frame(frm);
        push_event(MODE_START, 8'h00);
        push_frame({8'h01, 8'h03, 8'hFF});
    endtask

    task automatic drain();
        while (uart_events.size() != 0 || i_valid || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_SLAVE_ADDR: exp_addr = data[7:0];
            CFG_FUNC_CODE:  exp_func = data[6:0];
            CFG_TIMEOUT:    exp_timeout = data;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) predict_reply_check(i_mode, i_data_byte);
            if (!(i_valid && o_stall)) begin
                if (uart_events.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    next_item = uart_events.pop_front();
                    i_valid <= 1'b1;
                    i_mode <= next_item.mode;
                    i_data_byte <= next_item.data;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                verdicts_seen++;
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: verdict with none outstanding, diagnostic %0d",
                             $time, o_diagnostic);
                    mismatches++;
                end else begin
                    want = expected_verdicts.pop_front();
                    check_field("diagnostic", want.diagnostic, o_diagnostic);
                    check_field("measurement_valid", want.measurement_valid,
                                o_measurement_valid);
                    check_field("status_byte", want.status_byte, o_status_byte);
                    check_field("range_code", want.range_code, o_range_code);
                    check_field("meas_raw", want.meas_raw, o_meas_raw);
                    check_field("rx_crc", want.rx_crc, o_rx_crc);
                    check_field("calc_crc", want.calc_crc, o_calc_crc);
                    check_field("frm_len", want.frm_len, o_frm_len);
                    check_field("exc_code", want.exc_code, o_exc_code);
                    check_field("announced_length", want.announced_length,
                                o_announced_length);
                end
            end
            if (!hold_done && verdicts_seen == 15) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) hold_left--;
            i_stall <= (hold_left != 0) || ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("modbus_rtu_response_checker regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_directed();
        queue_random_replies(150);
        drain();

        write_reg(CFG_SLAVE_ADDR, 16'h0000);
        write_reg(CFG_FUNC_CODE, 16'h0000);
        write_reg(CFG_TIMEOUT, 16'h0001);
        write_reg(CFG_UNUSED, 16'($urandom_range(65535)));
        end_writes();
        queue_random_replies(150);
        drain();

        write_reg(CFG_SLAVE_ADDR, 16'hFFFF);
        write_reg(CFG_FUNC_CODE, 16'hFFFF);
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        end_writes();
        push_event(MODE_START, 8'h00);
        push_event(MODE_BYTE, exp_addr);
        push_event(MODE_BYTE, {1'b0, exp_func});
        repeat (100) push_event(MODE_TICK, 8'h00);
        queue_random_replies(150);
        drain();

        idle_pct = 0;
        write_reg(CFG_SLAVE_ADDR, 16'($urandom_range(65535)));
        write_reg(CFG_FUNC_CODE, 16'($urandom_range(65535)));
        write_reg(CFG_TIMEOUT, 16'($urandom_range(2, 40)));
        end_writes();
        queue_random_replies(150);
        drain();

        idle_pct = 35;
        write_reg(CFG_SLAVE_ADDR, 16'($urandom_range(65535)));
        write_reg(CFG_TIMEOUT, 16'h0000);
        end_writes();
        queue_random_replies(120);
        drain();

        write_reg(CFG_FUNC_CODE, 16'($urandom_range(65535)));
        write_reg(CFG_TIMEOUT, 16'($urandom_range(3, 300)));
        write_reg(CFG_SLAVE_ADDR, 16'($urandom_range(65535)));
        end_writes();
        queue_random_replies(150);
        drain();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("modbus_rtu_response_checker regression: pass");
        end else begin
            $display("modbus_rtu_response_checker regression: fail");
        end
        $finish;
    end

endmodule
